@@ sv/vbvp_pkg.sv @@
// shared types, codes and constants for the viewbox-to-viewport transform
package vbvp_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [3:0] ALIGN_UNKNOWN  = 4'd0;
  localparam logic [3:0] ALIGN_NONE     = 4'd1;
  localparam logic [3:0] ALIGN_XMINYMIN = 4'd2;
  localparam logic [3:0] ALIGN_XMIDYMIN = 4'd3;
  localparam logic [3:0] ALIGN_XMAXYMIN = 4'd4;
  localparam logic [3:0] ALIGN_XMINYMID = 4'd5;
  localparam logic [3:0] ALIGN_XMIDYMID = 4'd6;
  localparam logic [3:0] ALIGN_XMAXYMID = 4'd7;
  localparam logic [3:0] ALIGN_XMINYMAX = 4'd8;
  localparam logic [3:0] ALIGN_XMIDYMAX = 4'd9;
  localparam logic [3:0] ALIGN_XMAXYMAX = 4'd10;

  localparam logic [1:0] MOS_MEET  = 2'd1;
  localparam logic [1:0] MOS_SLICE = 2'd2;

  typedef enum logic [1:0] {
    POS_MIN = 2'd0,
    POS_MID = 2'd1,
    POS_MAX = 2'd2
  } pos_t;

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] bits;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] den;
    logic              sat;
  } div_stage_t;

  typedef struct packed {
    logic [WORD_W-1:0]        vpw;
    logic [WORD_W-1:0]        vph;
    logic signed [WORD_W-1:0] vbx;
    logic signed [WORD_W-1:0] vby;
    logic [WORD_W-1:0]        vbw;
    logic [WORD_W-1:0]        vbh;
    logic                     none;
    logic                     slice;
    pos_t                     xpos;
    pos_t                     ypos;
    logic                     err;
  } item_t;

  function automatic pos_t xpos_of(input logic [3:0] a);
    pos_t p;
    case (a)
      ALIGN_XMIDYMIN, ALIGN_XMIDYMID, ALIGN_XMIDYMAX: p = POS_MID;
      ALIGN_XMAXYMIN, ALIGN_XMAXYMID, ALIGN_XMAXYMAX: p = POS_MAX;
      default:                                        p = POS_MIN;
    endcase
    return p;
  endfunction

  function automatic pos_t ypos_of(input logic [3:0] a);
    pos_t p;
    case (a)
      ALIGN_XMINYMID, ALIGN_XMIDYMID, ALIGN_XMAXYMID: p = POS_MID;
      ALIGN_XMINYMAX, ALIGN_XMIDYMAX, ALIGN_XMAXYMAX: p = POS_MAX;
      default:                                        p = POS_MIN;
    endcase
    return p;
  endfunction

endpackage

@@ sv/viewbox_to_viewport_transform.sv @@
// top level: viewbox-to-viewport scale and translation pipeline
// Takes one transfer per cycle while in_ready is high. Each accepted transfer passes
// through 32 stages of the two radix-2 scale dividers, then equalize, multiply,
// offset and a saturating output register. The whole pipeline advances when
// the output register is empty or its result is taken, so ready drops only
// while a result waits downstream.
module viewbox_to_viewport_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] viewport_width,
  input  logic [31:0] viewport_height,
  input  logic signed [31:0] viewbox_x,
  input  logic signed [31:0] viewbox_y,
  input  logic [31:0] viewbox_width,
  input  logic [31:0] viewbox_height,
  input  logic [3:0]  align_mode,
  input  logic [1:0]  meet_or_slice,
  input  logic        ignore_align,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] scale_x,
  output logic [31:0] scale_y,
  output logic signed [31:0] translate_x,
  output logic signed [31:0] translate_y,
  output logic        divide_error
);

  localparam int unsigned W = vbvp_pkg::WORD_W;
  localparam int unsigned F = vbvp_pkg::FRAC_W;
  localparam int unsigned N = vbvp_pkg::DIV_STEPS;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // entry decode
  vbvp_pkg::item_t in_item;
  logic [3:0]      eff_align;
  always_comb begin
    if (ignore_align) begin
      eff_align = vbvp_pkg::ALIGN_XMINYMIN;
    end else if (align_mode == vbvp_pkg::ALIGN_UNKNOWN ||
                 align_mode > vbvp_pkg::ALIGN_XMAXYMAX) begin
      eff_align = vbvp_pkg::ALIGN_XMIDYMID;
    end else begin
      eff_align = align_mode;
    end
    in_item.vpw   = viewport_width;
    in_item.vph   = viewport_height;
    in_item.vbx   = viewbox_x;
    in_item.vby   = viewbox_y;
    in_item.vbw   = viewbox_width;
    in_item.vbh   = viewbox_height;
    in_item.none  = (eff_align == vbvp_pkg::ALIGN_NONE);
    in_item.slice = (meet_or_slice == vbvp_pkg::MOS_SLICE);
    in_item.xpos  = vbvp_pkg::xpos_of(eff_align);
    in_item.ypos  = vbvp_pkg::ypos_of(eff_align);
    in_item.err   = (viewbox_width == '0) || (viewbox_height == '0);
  end

  // divider stages with the item alongside
  logic [W-1:0] q_x, q_y;

  vbvp_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (viewport_width),
    .den (viewbox_width),
    .quo (q_x)
  );

  vbvp_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (viewport_height),
    .den (viewbox_height),
    .quo (q_y)
  );

  vbvp_pkg::item_t dly [0:N-1];
  logic [N-1:0]    dvld;

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= in_item;
      for (int i = 1; i < N; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else if (adv) begin
      dvld <= {dvld[N-2:0], in_valid};
    end
  end

  // stage a: equalize scales, pick the free axis
  vbvp_pkg::item_t d_it;
  logic            eq_next, take_x;
  assign d_it    = dly[N-1];
  assign eq_next = !d_it.none && (q_x != q_y);
  assign take_x  = d_it.slice ? (q_y < q_x) : (q_x < q_y);

  logic                a_vld, a_eq, a_err, a_isy;
  logic [W-1:0]        a_sx, a_sy, a_fs, a_box, a_port;
  logic signed [W-1:0] a_vbx, a_vby;
  vbvp_pkg::pos_t      a_pos;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_eq   <= eq_next;
      a_err  <= d_it.err;
      a_vbx  <= d_it.vbx;
      a_vby  <= d_it.vby;
      if (eq_next && take_x) begin
        a_sx   <= q_x;
        a_sy   <= q_x;
        a_fs   <= q_x;
        a_box  <= d_it.vbh;
        a_port <= d_it.vph;
        a_pos  <= d_it.ypos;
        a_isy  <= 1'b1;
      end else if (eq_next) begin
        a_sx   <= q_y;
        a_sy   <= q_y;
        a_fs   <= q_y;
        a_box  <= d_it.vbw;
        a_port <= d_it.vpw;
        a_pos  <= d_it.xpos;
        a_isy  <= 1'b0;
      end else begin
        a_sx   <= q_x;
        a_sy   <= q_y;
        a_fs   <= q_x;
        a_box  <= d_it.vbw;
        a_port <= d_it.vpw;
        a_pos  <= vbvp_pkg::POS_MIN;
        a_isy  <= 1'b0;
      end
    end
  end

  // stage b: products
  logic                b_vld, b_err, b_isy;
  logic [W-1:0]        b_sx, b_sy, b_port;
  vbvp_pkg::pos_t      b_pos;
  logic [2*W-1:0]      b_fit;
  logic signed [2*W:0] b_ox, b_oy;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_fit  <= a_fs * a_box;
      b_ox   <= $signed({1'b0, a_sx}) * a_vbx;
      b_oy   <= $signed({1'b0, a_sy}) * a_vby;
      b_sx   <= a_sx;
      b_sy   <= a_sy;
      b_port <= a_port;
      b_pos  <= a_pos;
      b_isy  <= a_isy;
      b_err  <= a_err;
    end
  end

  // stage c: free-axis offset and origin terms
  localparam int unsigned FIT_W = 2 * W - F;
  localparam int unsigned OFF_W = FIT_W + 1;

  logic signed [OFF_W-1:0] diff, off;
  assign diff = $signed({{(OFF_W-W){1'b0}}, b_port}) - $signed({1'b0, b_fit[2*W-1:F]});

  always_comb begin
    case (b_pos)
      vbvp_pkg::POS_MID: off = diff >>> 1;
      vbvp_pkg::POS_MAX: off = diff;
      default:           off = '0;
    endcase
  end

  logic                    c_vld, c_err;
  logic [W-1:0]            c_sx, c_sy;
  logic signed [OFF_W-1:0] c_offx, c_offy, c_ogx, c_ogy;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_offx <= b_isy ? '0 : off;
      c_offy <= b_isy ? off : '0;
      c_ogx  <= b_ox[2*W:F];
      c_ogy  <= b_oy[2*W:F];
      c_sx   <= b_sx;
      c_sy   <= b_sy;
      c_err  <= b_err;
    end
  end

  // stage d: translate and saturate into the output register
  logic signed [OFF_W:0] tx_full, ty_full;
  logic signed [W-1:0]   tx_sat, ty_sat;
  assign tx_full = $signed({c_offx[OFF_W-1], c_offx}) - $signed({c_ogx[OFF_W-1], c_ogx});
  assign ty_full = $signed({c_offy[OFF_W-1], c_offy}) - $signed({c_ogy[OFF_W-1], c_ogy});

  always_comb begin
    if (tx_full > $signed((OFF_W+1)'(32'sh7fffffff))) begin
      tx_sat = 32'sh7fffffff;
    end else if (tx_full < -$signed((OFF_W+1)'(33'sh080000000))) begin
      tx_sat = 32'sh80000000;
    end else begin
      tx_sat = tx_full[W-1:0];
    end
    if (ty_full > $signed((OFF_W+1)'(32'sh7fffffff))) begin
      ty_sat = 32'sh7fffffff;
    end else if (ty_full < -$signed((OFF_W+1)'(33'sh080000000))) begin
      ty_sat = 32'sh80000000;
    end else begin
      ty_sat = ty_full[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scale_x      <= c_err ? '0 : c_sx;
      scale_y      <= c_err ? '0 : c_sy;
      translate_x  <= c_err ? '0 : tx_sat;
      translate_y  <= c_err ? '0 : ty_sat;
      divide_error <= c_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_vld     <= dvld[N-1];
      b_vld     <= a_vld;
      c_vld     <= b_vld;
      out_valid <= c_vld;
    end
  end

  a_equalized: assert property (@(posedge clk) disable iff (rst)
    a_vld && a_eq |-> a_sx == a_sy)
    else $error("equalized scales differ");

  valid_moves: assert property (@(posedge clk) disable iff (rst)
    adv && b_vld |=> c_vld)
    else $error("pipeline valid lost on advance");

  error_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> scale_x == '0 && scale_y == '0 &&
      translate_x == '0 && translate_y == '0)
    else $error("error result not zeroed");

  stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(c_sx) && $stable(c_vld))
    else $error("pipeline moved while stalled");

endmodule

@@ sv/vbvp_div.sv @@
// pipelined restoring divider: saturated floor((num << 16) / den), one bit per stage
module vbvp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vbvp_pkg::WORD_W-1:0] num,
  input  logic [vbvp_pkg::WORD_W-1:0] den,
  output logic [vbvp_pkg::WORD_W-1:0] quo
);

  localparam int unsigned W = vbvp_pkg::WORD_W;
  localparam int unsigned F = vbvp_pkg::FRAC_W;
  localparam int unsigned N = vbvp_pkg::DIV_STEPS;

  vbvp_pkg::div_stage_t stg [0:N-1];
  vbvp_pkg::div_stage_t src [0:N-1];
  vbvp_pkg::div_stage_t stg_next [0:N-1];

  always_comb begin
    src[0].rem  = {{F{1'b0}}, num[W-1:F]};
    src[0].bits = {num[F-1:0], {(W-F){1'b0}}};
    src[0].quo  = '0;
    src[0].den  = den;
    src[0].sat  = ({{F{1'b0}}, num[W-1:F]} >= den);
    for (int i = 1; i < N; i++) begin
      src[i] = stg[i-1];
    end
  end

  always_comb begin
    logic [W:0] trial;
    logic       ge;
    for (int i = 0; i < N; i++) begin
      trial = {src[i].rem, src[i].bits[W-1]};
      ge    = (trial >= {1'b0, src[i].den});
      stg_next[i].rem  = ge ? W'(trial - {1'b0, src[i].den}) : trial[W-1:0];
      stg_next[i].bits = {src[i].bits[W-2:0], 1'b0};
      stg_next[i].quo  = {src[i].quo[W-2:0], ge};
      stg_next[i].den  = src[i].den;
      stg_next[i].sat  = src[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign quo = stg[N-1].sat ? {W{1'b1}} : stg[N-1].quo;

endmodule
